>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> src/rtal_pkg.sv
`default_nettype none

package rtal_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [7:0] LIFETIME_RESET = 8'd50;
    localparam logic [7:0] NO_COST        = 8'hFF;
    localparam logic [7:0] AGE_MAX        = 8'hFF;

    localparam logic [2:0] CMD_LOOKUP  = 3'd0;
    localparam logic [2:0] CMD_ADD     = 3'd1;
    localparam logic [2:0] CMD_REFRESH = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_ADD_FIN,
        ST_SLOT_FIN,
        ST_TICK
    } t_state;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef t_idx [ENTRIES-1:0] t_order;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  cost;
        logic [7:0]  wlinks;
        logic [15:0] seq;
    } t_entry;

    typedef struct packed {
        t_idx       rd_addr;
        logic       ent_we;
        logic       age_we;
        t_idx       wr_addr;
        t_entry     wr_ent;
        logic [7:0] wr_age;
    } t_mem_req;

    typedef struct packed {
        logic        found;
        logic [2:0]  slot_out;
        logic [15:0] hop_out;
        logic [7:0]  cost_out;
        logic [7:0]  weak_out;
        logic [15:0] seq_out;
        logic        evicted;
        logic [3:0]  removed_count;
    } t_result;

    // drop slot s from the recency list, keeping the order of the rest
    function automatic t_order unlink(t_order ord, t_cnt len, t_idx s);
        t_order res;
        t_cnt   k;
        res = ord;
        k   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (t_cnt'(i) < len && ord[i] != s) begin
                res[k[IDX_W-1:0]] = ord[i];
                k = k + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_cnt unlink_len(t_order ord, t_cnt len, t_idx s);
        t_cnt k;
        k = len;
        for (int i = 0; i < ENTRIES; i++) begin
            if (t_cnt'(i) < len && ord[i] == s) begin
                k = k - 1'b1;
            end
        end
        return k;
    endfunction

    function automatic t_order push_front(t_order ord, t_idx s);
        t_order res;
        res[0] = s;
        for (int i = 1; i < ENTRIES; i++) begin
            res[i] = ord[i-1];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/rtal_if.sv
`default_nettype none

interface rtal_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] dest_addr;
    logic [15:0] next_hop;
    logic [7:0]  add_cost;
    logic [7:0]  add_wlinks;
    logic [15:0] seq_num;
    logic [2:0]  slot;

    modport source (output valid, cmd, dest_addr, next_hop, add_cost, add_wlinks,
                    seq_num, slot, input ready);
    modport sink   (input valid, cmd, dest_addr, next_hop, add_cost, add_wlinks,
                    seq_num, slot, output ready);
endinterface

interface rtal_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [2:0]  slot_out;
    logic [15:0] hop_out;
    logic [7:0]  cost_out;
    logic [7:0]  weak_out;
    logic [15:0] seq_out;
    logic        evicted;
    logic [3:0]  removed_count;

    modport source (output valid, found, slot_out, hop_out, cost_out, weak_out, seq_out,
                    evicted, removed_count, input ready);
    modport sink   (input valid, found, slot_out, hop_out, cost_out, weak_out, seq_out,
                    evicted, removed_count, output ready);
endinterface

interface rtal_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/rtal_mem.sv
`default_nettype none

// entry payload and age stores, registered read
module rtal_mem (
    input  wire logic              i_clk,
    input  wire rtal_pkg::t_mem_req i_req,
    output rtal_pkg::t_entry       o_ent,
    output logic [7:0]             o_age
);

    rtal_pkg::t_entry ent_mem [rtal_pkg::ENTRIES];
    logic [7:0]       age_mem [rtal_pkg::ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.ent_we) begin
            ent_mem[i_req.wr_addr] <= i_req.wr_ent;
        end
        o_ent <= ent_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.age_we) begin
            age_mem[i_req.wr_addr] <= i_req.wr_age;
        end
        o_age <= age_mem[i_req.rd_addr];
    end

endmodule

`default_nettype wire

>>> src/route_table_aging_lookup_unit.sv
// route table with aging and oldest-entry eviction
// channels: i_item takes one command item (lookup, add, refresh, remove, tick),
// o_result gives exactly one result item per command, i_cfg writes the
// route lifetime (age in ticks at which an entry is dropped)
// one command is worked on at a time; i_item.ready is high only while the
// block is idle and the result register is empty
// work done per command before result valid is raised:
//   lookup          walks the recency list, one store read per entry
//   add             walks the list, then writes the entry in ST_ADD_FIN
//   refresh, remove one store read
//   tick            read-modify-write of every age
//   unused command  result valid right after the accepting edge
// throughput is bound by the single read port of the entry store, one entry
// per cycle during a walk; a new item is taken only once the last result is taken
// reset empties the table and sets the lifetime to 50; entry fields stay
// undefined until written, guarded by per-slot valid bits
// a stalled receiver holds the result register and no new item is taken
// until the result has been taken
`default_nettype none

module route_table_aging_lookup_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rtal_item_if.sink    i_item,
    rtal_result_if.source o_result,
    rtal_cfg_if.sink     i_cfg
);

    localparam int E = rtal_pkg::ENTRIES;

    // control state
    rtal_pkg::t_state  r_state, n_state;
    logic [7:0]        r_lifetime;
    logic [E-1:0]      r_valid, n_valid;
    rtal_pkg::t_order  r_order, n_order;
    rtal_pkg::t_cnt    r_len, n_len;
    rtal_pkg::t_cnt    r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_ov, n_ov;

    // latched command item
    logic [2:0]        r_cmd, n_cmd;
    logic [15:0]       r_dest, n_dest;
    logic [15:0]       r_hop, n_hop;
    logic [7:0]        r_cost, n_cost;
    logic [7:0]        r_wlinks, n_wlinks;
    logic [15:0]       r_seq, n_seq;
    logic [2:0]        r_slot, n_slot;

    // walk bookkeeping
    rtal_pkg::t_idx    r_pslot, n_pslot;
    logic              r_best_vld, n_best_vld;
    rtal_pkg::t_idx    r_best_slot, n_best_slot;
    logic [7:0]        r_lowest, n_lowest;
    rtal_pkg::t_entry  r_best_ent, n_best_ent;
    rtal_pkg::t_cnt    r_drop, n_drop;

    // result register
    rtal_pkg::t_result r_res, n_res;

    rtal_pkg::t_mem_req mem_req;
    rtal_pkg::t_entry   mem_ent;
    logic [7:0]         mem_age;

    logic               in_acc;
    logic               out_take;

    // add fill slot selection
    logic               free_vld;
    rtal_pkg::t_idx     free_slot;
    rtal_pkg::t_idx     add_slot;
    logic               add_evict;
    rtal_pkg::t_order   add_order;
    rtal_pkg::t_cnt     add_len;
    logic [7:0]         new_age;
    rtal_pkg::t_idx     sel_slot;
    logic               slot_ok;

    rtal_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_ent (mem_ent),
        .o_age (mem_age)
    );

    assign i_item.ready = (r_state == rtal_pkg::ST_IDLE) && !r_ov;
    assign in_acc       = i_item.valid && i_item.ready;
    assign out_take     = r_ov && o_result.ready;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid         = r_ov;
    assign o_result.found         = r_res.found;
    assign o_result.slot_out      = r_res.slot_out;
    assign o_result.hop_out       = r_res.hop_out;
    assign o_result.cost_out      = r_res.cost_out;
    assign o_result.weak_out      = r_res.weak_out;
    assign o_result.seq_out       = r_res.seq_out;
    assign o_result.evicted       = r_res.evicted;
    assign o_result.removed_count = r_res.removed_count;

    // lowest free slot for add
    always_comb begin
        free_vld  = 1'b0;
        free_slot = '0;
        for (int i = E - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_vld  = 1'b1;
                free_slot = rtal_pkg::IDX_W'(i);
            end
        end
    end

    // add target: reuse best hit with same hop, else free slot, else list tail
    always_comb begin
        add_evict = 1'b0;
        if (r_best_vld && r_best_ent.hop == r_hop) begin
            add_slot = r_best_slot;
        end else if (free_vld) begin
            add_slot = free_slot;
        end else begin
            add_slot  = r_order[rtal_pkg::IDX_W'(r_len - 1'b1)];
            add_evict = 1'b1;
        end
        add_order = rtal_pkg::push_front(rtal_pkg::unlink(r_order, r_len, add_slot),
                                         add_slot);
        add_len   = rtal_pkg::unlink_len(r_order, r_len, add_slot) + 1'b1;
    end

    assign new_age  = (mem_age == rtal_pkg::AGE_MAX) ? rtal_pkg::AGE_MAX : mem_age + 8'd1;
    assign sel_slot = rtal_pkg::IDX_W'(r_slot);
    assign slot_ok  = (32'(r_slot) < E) && r_valid[sel_slot];

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_order     = r_order;
        n_len       = r_len;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_ov        = r_ov;
        n_cmd       = r_cmd;
        n_dest      = r_dest;
        n_hop       = r_hop;
        n_cost      = r_cost;
        n_wlinks    = r_wlinks;
        n_seq       = r_seq;
        n_slot      = r_slot;
        n_pslot     = r_pslot;
        n_best_vld  = r_best_vld;
        n_best_slot = r_best_slot;
        n_lowest    = r_lowest;
        n_best_ent  = r_best_ent;
        n_drop      = r_drop;
        n_res       = r_res;

        mem_req         = '0;
        mem_req.rd_addr = rtal_pkg::IDX_W'(i_item.slot);

        if (out_take) begin
            n_ov = 1'b0;
        end

        case (r_state)
            rtal_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_cmd      = i_item.cmd;
                    n_dest     = i_item.dest_addr;
                    n_hop      = i_item.next_hop;
                    n_cost     = i_item.add_cost;
                    n_wlinks   = i_item.add_wlinks;
                    n_seq      = i_item.seq_num;
                    n_slot     = i_item.slot;
                    n_idx      = '0;
                    n_best_vld = 1'b0;
                    n_lowest   = rtal_pkg::NO_COST;
                    n_drop     = '0;
                    case (i_item.cmd)
                        rtal_pkg::CMD_LOOKUP,
                        rtal_pkg::CMD_ADD:     n_state = rtal_pkg::ST_WALK;
                        rtal_pkg::CMD_REFRESH,
                        rtal_pkg::CMD_REMOVE:  n_state = rtal_pkg::ST_SLOT_FIN;
                        rtal_pkg::CMD_TICK:    n_state = rtal_pkg::ST_TICK;
                        default: begin
                            n_res = '0;
                            n_ov  = 1'b1;
                        end
                    endcase
                end
            end

            rtal_pkg::ST_WALK: begin
                // compare the entry read last cycle
                if (r_pend && mem_ent.dest == r_dest && mem_ent.cost < r_lowest) begin
                    n_lowest    = mem_ent.cost;
                    n_best_vld  = 1'b1;
                    n_best_slot = r_pslot;
                    n_best_ent  = mem_ent;
                end
                // issue the next list entry
                if (r_idx < r_len) begin
                    mem_req.rd_addr = r_order[r_idx[rtal_pkg::IDX_W-1:0]];
                    n_pslot         = r_order[r_idx[rtal_pkg::IDX_W-1:0]];
                    n_pend          = 1'b1;
                    n_idx           = r_idx + 1'b1;
                end else if (!r_pend) begin
                    if (r_cmd == rtal_pkg::CMD_ADD) begin
                        n_state = rtal_pkg::ST_ADD_FIN;
                    end else begin
                        n_res = '0;
                        if (r_best_vld) begin
                            n_res.found    = 1'b1;
                            n_res.slot_out = 3'(r_best_slot);
                            n_res.hop_out  = r_best_ent.hop;
                            n_res.cost_out = r_best_ent.cost;
                            n_res.weak_out = r_best_ent.wlinks;
                            n_res.seq_out  = r_best_ent.seq;
                        end
                        n_ov    = 1'b1;
                        n_state = rtal_pkg::ST_IDLE;
                    end
                end
            end

            rtal_pkg::ST_ADD_FIN: begin
                mem_req.ent_we        = 1'b1;
                mem_req.age_we        = 1'b1;
                mem_req.wr_addr       = add_slot;
                mem_req.wr_ent.dest   = r_dest;
                mem_req.wr_ent.hop    = r_hop;
                mem_req.wr_ent.cost   = r_cost;
                mem_req.wr_ent.wlinks = r_wlinks;
                mem_req.wr_ent.seq    = r_seq;
                mem_req.wr_age        = '0;
                n_valid[add_slot]     = 1'b1;
                n_order               = add_order;
                n_len                 = add_len;
                n_res                 = '0;
                n_res.slot_out        = 3'(add_slot);
                n_res.hop_out         = r_hop;
                n_res.cost_out        = r_cost;
                n_res.weak_out        = r_wlinks;
                n_res.seq_out         = r_seq;
                n_res.evicted         = add_evict;
                n_ov                  = 1'b1;
                n_state               = rtal_pkg::ST_IDLE;
            end

            rtal_pkg::ST_SLOT_FIN: begin
                n_res          = '0;
                n_res.slot_out = r_slot;
                if (slot_ok) begin
                    n_res.found    = 1'b1;
                    n_res.hop_out  = mem_ent.hop;
                    n_res.cost_out = mem_ent.cost;
                    n_res.weak_out = mem_ent.wlinks;
                    n_res.seq_out  = mem_ent.seq;
                    if (r_cmd == rtal_pkg::CMD_REFRESH) begin
                        mem_req.age_we  = 1'b1;
                        mem_req.wr_addr = sel_slot;
                        mem_req.wr_age  = '0;
                    end else begin
                        n_valid[sel_slot] = 1'b0;
                        n_order = rtal_pkg::unlink(r_order, r_len, sel_slot);
                        n_len   = rtal_pkg::unlink_len(r_order, r_len, sel_slot);
                    end
                end
                n_ov    = 1'b1;
                n_state = rtal_pkg::ST_IDLE;
            end

            rtal_pkg::ST_TICK: begin
                // age update for the slot read last cycle
                if (r_pend && r_valid[r_pslot]) begin
                    if (new_age >= r_lifetime) begin
                        n_valid[r_pslot] = 1'b0;
                        n_order = rtal_pkg::unlink(r_order, r_len, r_pslot);
                        n_len   = rtal_pkg::unlink_len(r_order, r_len, r_pslot);
                        n_drop  = r_drop + 1'b1;
                    end else begin
                        mem_req.age_we  = 1'b1;
                        mem_req.wr_addr = r_pslot;
                        mem_req.wr_age  = new_age;
                    end
                end
                if (r_idx < rtal_pkg::CNT_W'(E)) begin
                    mem_req.rd_addr = r_idx[rtal_pkg::IDX_W-1:0];
                    n_pslot         = r_idx[rtal_pkg::IDX_W-1:0];
                    n_pend          = 1'b1;
                    n_idx           = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_res               = '0;
                    n_res.removed_count = 4'(r_drop);
                    n_ov                = 1'b1;
                    n_state             = rtal_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = rtal_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rtal_pkg::ST_IDLE;
            r_lifetime <= rtal_pkg::LIFETIME_RESET;
            r_valid    <= '0;
            r_len      <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                r_lifetime <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_order     <= n_order;
        r_cmd       <= n_cmd;
        r_dest      <= n_dest;
        r_hop       <= n_hop;
        r_cost      <= n_cost;
        r_wlinks    <= n_wlinks;
        r_seq       <= n_seq;
        r_slot      <= n_slot;
        r_pslot     <= n_pslot;
        r_best_vld  <= n_best_vld;
        r_best_slot <= n_best_slot;
        r_lowest    <= n_lowest;
        r_best_ent  <= n_best_ent;
        r_drop      <= n_drop;
        r_res       <= n_res;
    end

endmodule

`default_nettype wire

>>> src/rtal_checker.sv
`default_nettype none
`include "assert_macros.svh"

module rtal_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_found,
    input wire logic [2:0]  out_slot,
    input wire logic        out_evicted,
    input wire logic [3:0]  out_removed
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_IMPLY(a_found_no_evict, i_clk, i_rst_n, out_valid && out_found,
                  !out_evicted && out_removed == 4'd0)
    `ASSERT_IMPLY(a_tick_clean, i_clk, i_rst_n, out_valid && out_removed != 4'd0,
                  !out_found && out_slot == 3'd0 && !out_evicted)

endmodule

bind route_table_aging_lookup_unit rtal_checker u_rtal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_item.valid),
    .in_ready    (i_item.ready),
    .out_valid   (o_result.valid),
    .out_ready   (o_result.ready),
    .out_found   (o_result.found),
    .out_slot    (o_result.slot_out),
    .out_evicted (o_result.evicted),
    .out_removed (o_result.removed_count)
);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // one route slot as the testbench sees it
    typedef struct {
        bit          valid;
        logic [15:0] dest;
        logic [15:0] hop;
        logic [7:0]  cost;
        logic [7:0]  wlinks;
        logic [15:0] seq;
        logic [7:0]  age;
    } t_route;

    // routing table shadow: predicts one result per accepted command item
    class t_route_scoreboard;
        t_route            table_q[rtal_pkg::ENTRIES];
        int unsigned       recency[$];
        logic [7:0]        lifetime;
        rtal_pkg::t_result pending_q[$];
        int                mismatches;

        function void clear();
            foreach (table_q[i]) table_q[i].valid = 0;
            recency.delete();
            lifetime = rtal_pkg::LIFETIME_RESET;
            pending_q.delete();
            mismatches = 0;
        endfunction

        function void drop_from_list(int unsigned s);
            foreach (recency[i]) begin
                if (recency[i] == s) begin
                    recency.delete(i);
                    return;
                end
            end
        endfunction

        // lowest cost below 255 among matching entries, list front wins ties
        function int best_route(logic [15:0] dest);
            int          best;
            logic [8:0]  lowest;
            best = -1;
            lowest = 9'(rtal_pkg::NO_COST);
            foreach (recency[i]) begin
                if (table_q[recency[i]].valid && table_q[recency[i]].dest == dest &&
                    9'(table_q[recency[i]].cost) < lowest) begin
                    lowest = 9'(table_q[recency[i]].cost);
                    best = int'(recency[i]);
                end
            end
            return best;
        endfunction

        function void fill_fields(ref rtal_pkg::t_result r, input int unsigned s);
            r.slot_out = 3'(s);
            r.hop_out  = table_q[s].hop;
            r.cost_out = table_q[s].cost;
            r.weak_out = table_q[s].wlinks;
            r.seq_out  = table_q[s].seq;
        endfunction

        function void note_command(logic [2:0] cmd, logic [15:0] dest, logic [15:0] hop,
                                   logic [7:0] cost, logic [7:0] wlinks, logic [15:0] seq,
                                   logic [2:0] slot);
            rtal_pkg::t_result r;
            int                b;
            int unsigned       s;
            bit                got;
            int unsigned       dropped;
            r = '0;
            case (cmd)
                rtal_pkg::CMD_LOOKUP: begin
                    b = best_route(dest);
                    if (b >= 0) begin
                        r.found = 1;
                        fill_fields(r, b);
                    end
                end
                rtal_pkg::CMD_ADD: begin
                    b = best_route(dest);
                    s = 0;
                    if (b >= 0 && table_q[b].hop == hop) begin
                        s = b;
                        drop_from_list(s);
                    end else begin
                        got = 0;
                        for (int i = 0; i < rtal_pkg::ENTRIES; i++) begin
                            if (!got && !table_q[i].valid) begin
                                s = i;
                                got = 1;
                            end
                        end
                        if (!got) begin
                            s = recency[$];
                            drop_from_list(s);
                            r.evicted = 1;
                        end
                    end
                    table_q[s] = '{1, dest, hop, cost, wlinks, seq, 8'd0};
                    recency.push_front(s);
                    fill_fields(r, s);
                end
                rtal_pkg::CMD_REFRESH, rtal_pkg::CMD_REMOVE: begin
                    r.slot_out = slot;
                    if (table_q[slot].valid) begin
                        r.found = 1;
                        fill_fields(r, slot);
                        if (cmd == rtal_pkg::CMD_REFRESH) begin
                            table_q[slot].age = 0;
                        end else begin
                            table_q[slot].valid = 0;
                            drop_from_list(slot);
                        end
                    end
                end
                rtal_pkg::CMD_TICK: begin
                    dropped = 0;
                    for (int i = 0; i < rtal_pkg::ENTRIES; i++) begin
                        if (table_q[i].valid) begin
                            if (table_q[i].age != rtal_pkg::AGE_MAX) table_q[i].age++;
                            if (table_q[i].age >= lifetime) begin
                                table_q[i].valid = 0;
                                drop_from_list(i);
                                dropped++;
                            end
                        end
                    end
                    r.removed_count = 4'(dropped);
                end
                default: ;
            endcase
            pending_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_result(rtal_pkg::t_result got);
            rtal_pkg::t_result want;
            if (pending_q.size() == 0) begin
                $display("result with nothing expected at %0t", $realtime);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (got.found != want.found) report_mismatch("found", got.found, want.found);
            if (got.slot_out != want.slot_out)
                report_mismatch("slot_out", got.slot_out, want.slot_out);
            if (got.hop_out != want.hop_out) report_mismatch("hop_out", got.hop_out, want.hop_out);
            if (got.cost_out != want.cost_out)
                report_mismatch("cost_out", got.cost_out, want.cost_out);
            if (got.weak_out != want.weak_out)
                report_mismatch("weak_out", got.weak_out, want.weak_out);
            if (got.seq_out != want.seq_out) report_mismatch("seq_out", got.seq_out, want.seq_out);
            if (got.evicted != want.evicted) report_mismatch("evicted", got.evicted, want.evicted);
            if (got.removed_count != want.removed_count)
                report_mismatch("removed_count", got.removed_count, want.removed_count);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;

    rtal_item_if   item_ch();
    rtal_result_if result_ch();
    rtal_cfg_if    cfg_ch();

    route_table_aging_lookup_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_result(result_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    t_route_scoreboard routes = new();

    // idling mix: percent of cycles each side sits out
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off = 0;     // long receiver hold-off
    int unsigned idle_cycles = 0;
    bit          timed_out = 0;

    // small pool of addresses so lookups and adds collide often
    logic [15:0] dest_pool[4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};
    logic [15:0] hop_pool[3]  = '{16'h0000, 16'hFFFF, 16'h00A5};

    // receiver: ready toggles at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 0;
        end else begin
            result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sample at the rising edge: results and the idle watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                routes.check_result('{result_ch.found, result_ch.slot_out, result_ch.hop_out,
                                      result_ch.cost_out, result_ch.weak_out,
                                      result_ch.seq_out, result_ch.evicted,
                                      result_ch.removed_count});
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
        end
    end

    // valid stays up after an accept until the next item or an idle cycle;
    // the block drops ready right after each accept
    task automatic send_command(logic [2:0] cmd, logic [15:0] dest, logic [15:0] hop,
                                logic [7:0] cost, logic [7:0] wlinks, logic [15:0] seq,
                                logic [2:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 0;
            @(negedge i_clk);
        end
        item_ch.valid      <= 1;
        item_ch.cmd        <= cmd;
        item_ch.dest_addr  <= dest;
        item_ch.next_hop   <= hop;
        item_ch.add_cost   <= cost;
        item_ch.add_wlinks <= wlinks;
        item_ch.seq_num    <= seq;
        item_ch.slot       <= slot;
        do @(posedge i_clk); while (!(item_ch.ready && item_ch.valid));
        routes.note_command(cmd, dest, hop, cost, wlinks, seq, slot);
        @(negedge i_clk);
    endtask

    // let every expected result arrive, then the longest command latency
    task automatic drain();
        item_ch.valid <= 0;
        while (routes.pending_q.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (rtal_pkg::ENTRIES + 6) @(negedge i_clk);
    endtask

    // only done while the block is idle
    task automatic write_lifetime(logic [7:0] value);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        routes.lifetime = value;
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic random_command();
        int unsigned pick;
        logic [2:0]  cmd;
        logic [15:0] dest;
        logic [7:0]  cost;
        pick = $urandom_range(99);
        if (pick < 30)      cmd = rtal_pkg::CMD_ADD;
        else if (pick < 55) cmd = rtal_pkg::CMD_LOOKUP;
        else if (pick < 70) cmd = rtal_pkg::CMD_REFRESH;
        else if (pick < 80) cmd = rtal_pkg::CMD_REMOVE;
        else if (pick < 95) cmd = rtal_pkg::CMD_TICK;
        else                cmd = 3'($urandom_range(7, 5));
        dest = ($urandom_range(9) < 8) ? dest_pool[$urandom_range(3)] : 16'($urandom);
        cost = ($urandom_range(9) == 0) ? rtal_pkg::NO_COST : 8'($urandom);
        send_command(cmd, dest,
                     ($urandom_range(1) == 0) ? hop_pool[$urandom_range(2)] : 16'($urandom),
                     cost, 8'($urandom), 16'($urandom), 3'($urandom));
    endtask

    task automatic random_phase(int unsigned count, int unsigned send_pct,
                                int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            if (timed_out) return;
            random_command();
        end
    endtask

    always @(posedge i_clk) begin
        if (timed_out) begin
            $display("** route_table_aging_lookup_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        item_ch.valid = 0;
        item_ch.cmd = rtal_pkg::CMD_LOOKUP;
        item_ch.dest_addr = 0;
        item_ch.next_hop = 0;
        item_ch.add_cost = 0;
        item_ch.add_wlinks = 0;
        item_ch.seq_num = 0;
        item_ch.slot = 0;
        cfg_ch.valid = 0;
        cfg_ch.data = 0;
        routes.clear();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: empty table, extremes, cost 255, ties, eviction, bad slots
        send_command(rtal_pkg::CMD_LOOKUP, 16'hFFFF, 0, 0, 0, 0, 0);
        send_command(rtal_pkg::CMD_REFRESH, 0, 0, 0, 0, 0, 3'd7);
        send_command(rtal_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 3'd0);
        send_command(rtal_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, rtal_pkg::NO_COST, 8'hFF,
                     16'hFFFF, 0);
        send_command(rtal_pkg::CMD_LOOKUP, 16'hFFFF, 0, 0, 0, 0, 0);
        send_command(rtal_pkg::CMD_ADD, 16'h0000, 16'h0000, 8'd0, 8'd0, 16'h0000, 0);
        send_command(rtal_pkg::CMD_ADD, 16'h0000, 16'h1111, 8'd0, 8'd1, 16'h0001, 0);
        send_command(rtal_pkg::CMD_LOOKUP, 16'h0000, 0, 0, 0, 0, 0);
        send_command(rtal_pkg::CMD_ADD, 16'h0000, 16'h1111, 8'd5, 8'd2, 16'h0002, 0);
        for (int i = 0; i < 7; i++)
            send_command(rtal_pkg::CMD_ADD, 16'(i + 100), 16'(i), 8'(i), 8'(i), 16'(i), 0);
        send_command(rtal_pkg::CMD_REFRESH, 0, 0, 0, 0, 0, 3'd2);
        send_command(rtal_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 3'd3);
        send_command(rtal_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 3'd3);
        send_command(3'd5, 16'hFFFF, 0, 0, 0, 0, 0);
        send_command(3'd7, 0, 0, 0, 0, 0, 0);
        send_command(rtal_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);

        // lifetime 1 drops everything on one tick
        write_lifetime(8'd1);
        send_command(rtal_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
        write_lifetime(8'd3);
        random_phase(150, 0, 0);
        write_lifetime(8'd255);
        random_phase(120, 75, 0);

        // long receiver hold-off while items keep coming
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            random_phase(10, 0, 0);
        join
        write_lifetime(8'd0);
        send_command(rtal_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
        write_lifetime(8'd6);
        random_phase(120, 0, 75);
        write_lifetime(rtal_pkg::LIFETIME_RESET);
        random_phase(120, 11, 11);
        write_lifetime(8'd2);
        random_phase(120, 0, 0);

        drain();
        if (routes.mismatches == 0 && routes.pending_q.size() == 0) begin
            $display("** route_table_aging_lookup_unit: PASSED **");
        end else begin
            $display("** route_table_aging_lookup_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
